FILE: design/ets2c_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ets2c_pkg
// Shared constants, types and tables of the epoch-to-calendar pipeline.
// ----------------------------------------------------------------------------
package ets2c_pkg;

  // Pipeline shape: three day-split stages, then six calendar stages
  localparam int unsigned SplitStages = 3;
  localparam int unsigned CalStages   = 6;
  localparam int unsigned NumStages   = SplitStages + CalStages;

  // Field widths
  localparam int unsigned EpochW  = 32;
  localparam int unsigned OffsetW = 17;
  localparam int unsigned SodW    = 17;  // second of day, 0..86399
  localparam int unsigned JdayW   = 20;  // shifted day number

  // Bias that lifts every offset sum to a non-negative multiple-of-day frame
  localparam logic [32:0] DayBias   = 33'd2147558400;  // 24856 days
  localparam logic [19:0] JdayShift = 20'd694613;      // 719469 - 24856

  // Reciprocals: floor(x / D) = (x * R) >> S, exact over the used range
  localparam logic [26:0] Recip675  = 27'd101806633;   // S = 36, x < 2^26
  localparam logic [15:0] Recip15   = 16'd34953;       // S = 19
  localparam logic [11:0] Recip60   = 12'd2185;        // S = 17
  localparam logic [20:0] Recip7    = 21'd1198373;     // S = 23
  localparam logic [17:0] Recip1461 = 18'd183735;      // S = 28
  localparam logic [10:0] Recip153  = 11'd1714;        // S = 18
  localparam logic [7:0]  Recip5    = 8'd205;          // S = 10

  // Century starts in quarter days (century = 146097 / 4 days), 19 and 20
  localparam logic [21:0] EraLo = 22'd2775843;  // 19 * 146097
  localparam logic [21:0] EraHi = 22'd2921940;  // 20 * 146097

  // Time of day
  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
  } tod_t;

  // Calendar date
  typedef struct packed {
    logic [2:0] weekday;
    logic [7:0] years_since_1900;
    logic [3:0] month;
    logic [4:0] day_of_month;
    logic [8:0] day_of_year;
  } date_t;

  // Days before the first of each month in a common year
  function automatic logic [8:0] month_start(input logic [3:0] month);
    logic [8:0] days;
    unique case (month)
      4'd0:    days = 9'd0;
      4'd1:    days = 9'd31;
      4'd2:    days = 9'd59;
      4'd3:    days = 9'd90;
      4'd4:    days = 9'd120;
      4'd5:    days = 9'd151;
      4'd6:    days = 9'd181;
      4'd7:    days = 9'd212;
      4'd8:    days = 9'd243;
      4'd9:    days = 9'd273;
      4'd10:   days = 9'd304;
      4'd11:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

FILE: design/epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts signed Unix seconds plus a zone offset to a Gregorian calendar time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o with epoch_seconds_i. A transfer
//   happens on a rising edge with valid high and stall low.
//   Output channel: out_valid_o / out_stall_i with second_o .. day_of_year_o,
//   one result per input, in input order.
//   Configuration: cfg_we_i writes cfg_wdata_i into the zone offset (signed
//   seconds). Write it only while no item is in flight.
//   Stages: an input transfer passes through the nine register stages (day
//   split by reciprocal multiply, time-of-day split, era / year / month /
//   day reciprocal divisions) before out_valid_o rises.
//   Throughput: one item per cycle while in_stall_o is low. Empty stages fill
//   even while the output is stalled; in_stall_o rises only when every stage
//   holds an item and the receiver stalls. A stalled result holds its value.
//   Reset: rst_ni (async, active low) empties the pipeline and clears the
//   zone offset to 0. There is no clearing pass.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic signed [ets2c_pkg::OffsetW-1:0] cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [ets2c_pkg::EpochW-1:0]  epoch_seconds_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [5:0]                           second_o,
  output logic [5:0]                           minute_o,
  output logic [4:0]                           hour_o,
  output logic [2:0]                           weekday_o,
  output logic [7:0]                           years_since_1900_o,
  output logic [3:0]                           month_o,
  output logic [4:0]                           day_of_month_o,
  output logic [8:0]                           day_of_year_o
);

  logic signed [ets2c_pkg::OffsetW-1:0] zone_offset_q;
  logic [ets2c_pkg::NumStages-1:0]      load;
  logic [ets2c_pkg::SodW-1:0]           sod;
  logic [ets2c_pkg::JdayW-1:0]          jday;
  ets2c_pkg::tod_t                      tod;
  ets2c_pkg::date_t                     date;

  // Hold the zone offset register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_offset_q <= '0;
    end else if (cfg_we_i) begin
      zone_offset_q <= cfg_wdata_i;
    end
  end

  ets2c_pipe_ctrl u_pipe_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .load_o      (load)
  );

  ets2c_day_split u_day_split (
    .clk_i           (clk_i),
    .ld_i            (load[ets2c_pkg::SplitStages-1:0]),
    .epoch_seconds_i (epoch_seconds_i),
    .zone_offset_i   (zone_offset_q),
    .sod_o           (sod),
    .jday_o          (jday)
  );

  ets2c_time_of_day u_time_of_day (
    .clk_i (clk_i),
    .ld_i  (load[ets2c_pkg::NumStages-1:ets2c_pkg::SplitStages]),
    .sod_i (sod),
    .tod_o (tod)
  );

  ets2c_civil_date u_civil_date (
    .clk_i  (clk_i),
    .ld_i   (load[ets2c_pkg::NumStages-1:ets2c_pkg::SplitStages]),
    .jday_i (jday),
    .date_o (date)
  );

  // Drive result fields from the last stage
  assign second_o           = tod.second;
  assign minute_o           = tod.minute;
  assign hour_o             = tod.hour;
  assign weekday_o          = date.weekday;
  assign years_since_1900_o = date.years_since_1900;
  assign month_o            = date.month;
  assign day_of_month_o     = date.day_of_month;
  assign day_of_year_o      = date.day_of_year;

endmodule

FILE: design/ets2c_pipe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ets2c_pipe_ctrl
// Valid bits and per-stage load enables of the pipeline; bubbles collapse.
// ----------------------------------------------------------------------------
module ets2c_pipe_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ets2c_pkg::NumStages-1:0]    load_o
);

  logic [ets2c_pkg::NumStages-1:0] valid_q, valid_d;
  logic [ets2c_pkg::NumStages-1:0] vin;
  logic [ets2c_pkg::NumStages:0]   rdy;

  // A stage may take new data when empty or when its content moves on
  always_comb begin
    rdy[ets2c_pkg::NumStages] = !out_stall_i;
    for (int k = ets2c_pkg::NumStages - 1; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  assign vin     = {valid_q[ets2c_pkg::NumStages-2:0], in_valid_i};
  assign load_o  = vin & rdy[ets2c_pkg::NumStages-1:0];
  assign valid_d = (rdy[ets2c_pkg::NumStages-1:0] & vin)
                 | (~rdy[ets2c_pkg::NumStages-1:0] & valid_q);

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = valid_q[ets2c_pkg::NumStages-1];

endmodule

FILE: design/ets2c_day_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ets2c_day_split
// Adds the zone offset and splits the time into day number and second of day.
// ----------------------------------------------------------------------------
module ets2c_day_split (
  input  logic                                 clk_i,
  input  logic [ets2c_pkg::SplitStages-1:0]    ld_i,
  input  logic signed [ets2c_pkg::EpochW-1:0]  epoch_seconds_i,
  input  logic signed [ets2c_pkg::OffsetW-1:0] zone_offset_i,
  output logic [ets2c_pkg::SodW-1:0]           sod_o,
  output logic [ets2c_pkg::JdayW-1:0]          jday_o
);

  logic [32:0] biased_d, biased_q;
  logic [32:0] biased1_q;
  logic [52:0] day_prod;
  logic [16:0] days_d, days_q;
  logic [26:0] days_x675;
  logic [25:0] rem_full;
  logic [ets2c_pkg::SodW-1:0]  sod_d, sod_q;
  logic [ets2c_pkg::JdayW-1:0] jday_d, jday_q;

  // Stage 0: exact sum plus bias, always non-negative in 33 bits
  assign biased_d = {epoch_seconds_i[31], epoch_seconds_i}
                  + {{16{zone_offset_i[16]}}, zone_offset_i}
                  + ets2c_pkg::DayBias;

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      biased_q <= biased_d;
    end
  end

  // Stage 1: days = (biased >> 7) / 675 by reciprocal
  assign day_prod = 53'(biased_q[32:7]) * 53'(ets2c_pkg::Recip675);
  assign days_d   = day_prod[52:36];

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      days_q    <= days_d;
      biased1_q <= biased_q;
    end
  end

  // Stage 2: remainder gives second of day; shift day number
  assign days_x675 = 27'(days_q) * 27'd675;
  assign rem_full  = biased1_q[32:7] - days_x675[25:0];
  assign sod_d     = {rem_full[9:0], biased1_q[6:0]};
  assign jday_d    = {3'b000, days_q} + ets2c_pkg::JdayShift;

  always_ff @(posedge clk_i) begin
    if (ld_i[2]) begin
      sod_q  <= sod_d;
      jday_q <= jday_d;
    end
  end

  assign sod_o  = sod_q;
  assign jday_o = jday_q;

endmodule

FILE: design/ets2c_time_of_day.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ets2c_time_of_day
// Splits the second of day into hour, minute and second, then aligns them.
// ----------------------------------------------------------------------------
module ets2c_time_of_day (
  input  logic                               clk_i,
  input  logic [ets2c_pkg::CalStages-1:0]    ld_i,
  input  logic [ets2c_pkg::SodW-1:0]         sod_i,
  output ets2c_pkg::tod_t                    tod_o
);

  logic [30:0] min_prod;
  logic [10:0] mins_d, mins0_q, mins1_q;
  logic [ets2c_pkg::SodW-1:0] sod0_q;
  logic [16:0] mins_x60;
  logic [22:0] hour_prod;
  logic [5:0]  sec_d;
  logic [4:0]  hour_d;
  logic [5:0]  sec1_q;
  logic [4:0]  hour1_q;
  logic [10:0] hour_x60;
  logic [5:0]  min_d;
  ets2c_pkg::tod_t tod2_q, tod3_q, tod4_q, tod5_q;

  // Stage 0: total minutes = (sod >> 2) / 15
  assign min_prod = 31'(sod_i[16:2]) * 31'(ets2c_pkg::Recip15);
  assign mins_d   = min_prod[29:19];

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      mins0_q <= mins_d;
      sod0_q  <= sod_i;
    end
  end

  // Stage 1: seconds remainder and hour = minutes / 60
  assign mins_x60  = 17'(mins0_q) * 17'd60;
  assign sec_d     = 6'(sod0_q - mins_x60);
  assign hour_prod = 23'(mins0_q) * 23'(ets2c_pkg::Recip60);
  assign hour_d    = hour_prod[21:17];

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      sec1_q  <= sec_d;
      hour1_q <= hour_d;
      mins1_q <= mins0_q;
    end
  end

  // Stage 2: minute of hour
  assign hour_x60 = 11'(hour1_q) * 11'd60;
  assign min_d    = 6'(mins1_q - hour_x60);

  always_ff @(posedge clk_i) begin
    if (ld_i[2]) begin
      tod2_q <= '{second: sec1_q, minute: min_d, hour: hour1_q};
    end
  end

  // Stages 3 to 5: hold alignment with the date path
  always_ff @(posedge clk_i) begin
    if (ld_i[3]) begin
      tod3_q <= tod2_q;
    end
    if (ld_i[4]) begin
      tod4_q <= tod3_q;
    end
    if (ld_i[5]) begin
      tod5_q <= tod4_q;
    end
  end

  assign tod_o = tod5_q;

endmodule

FILE: design/ets2c_civil_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ets2c_civil_date
// Turns the shifted day number into weekday, year, month, day and day of year.
// ----------------------------------------------------------------------------
module ets2c_civil_date (
  input  logic                               clk_i,
  input  logic [ets2c_pkg::CalStages-1:0]    ld_i,
  input  logic [ets2c_pkg::JdayW-1:0]        jday_i,
  output ets2c_pkg::date_t                   date_o
);

  // Weekday path
  logic [19:0] wk_x;
  logic [40:0] wk_prod;
  logic [19:0] wk_x0_q;
  logic [16:0] wk_q0_q;
  logic [19:0] wk_q7;
  logic [2:0]  wday_d;
  logic [2:0]  wday1_q, wday2_q, wday3_q, wday4_q;

  // Date path
  logic [21:0] era_a;
  logic        era_hi;
  logic [21:0] era_rem;
  logic [15:0] doe0_q;
  logic        hi0_q, hi1_q, hi2_q, hi3_q;
  logic [17:0] yoe_x;
  logic [35:0] yoe_prod;
  logic [17:0] x1_q;
  logic [6:0]  yoe1_q, yoe2_q, yoe3_q;
  logic [17:0] yoe_x1461;
  logic [10:0] doy_raw;
  logic [10:0] doy_p4;
  logic [8:0]  dn2_q;
  logic [10:0] mp_y;
  logic [21:0] mp_prod;
  logic [10:0] mp_y3_q;
  logic [3:0]  mp3_q;
  logic [10:0] mp_x153;
  logic [7:0]  d4_d;
  logic        carry;
  logic [3:0]  month_d;
  logic [6:0]  yoc;
  logic        leap_d;
  logic [7:0]  yrs_d;
  logic [7:0]  d4_4_q;
  logic [3:0]  month4_q;
  logic [7:0]  yrs4_q;
  logic        leap4_q;
  logic [7:0]  d5_x;
  logic [15:0] dom_prod;
  logic [4:0]  dom_d;
  logic [8:0]  yday_d;
  ets2c_pkg::date_t date5_q;

  // Stage 0: weekday quotient; era and day of era
  assign wk_x    = jday_i + 20'd2;
  assign wk_prod = 41'(wk_x) * 41'(ets2c_pkg::Recip7);
  assign era_a   = {jday_i, 2'b00} - 22'd1;
  assign era_hi  = era_a >= ets2c_pkg::EraHi;
  assign era_rem = era_a - (era_hi ? ets2c_pkg::EraHi : ets2c_pkg::EraLo);

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      wk_x0_q <= wk_x;
      wk_q0_q <= wk_prod[39:23];
      doe0_q  <= era_rem[17:2];
      hi0_q   <= era_hi;
    end
  end

  // Stage 1: weekday remainder; year of era = (4d + 3) / 1461
  assign wk_q7    = 20'(wk_q0_q) * 20'd7;
  assign wday_d   = 3'(wk_x0_q - wk_q7);
  assign yoe_x    = {doe0_q, 2'b11};
  assign yoe_prod = 36'(yoe_x) * 36'(ets2c_pkg::Recip1461);

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      wday1_q <= wday_d;
      x1_q    <= yoe_x;
      yoe1_q  <= yoe_prod[34:28];
      hi1_q   <= hi0_q;
    end
  end

  // Stage 2: day within the March-based year, from 1
  assign yoe_x1461 = 18'(yoe1_q) * 18'd1461;
  assign doy_raw   = 11'(x1_q - yoe_x1461);
  assign doy_p4    = doy_raw + 11'd4;

  always_ff @(posedge clk_i) begin
    if (ld_i[2]) begin
      wday2_q <= wday1_q;
      dn2_q   <= doy_p4[10:2];
      yoe2_q  <= yoe1_q;
      hi2_q   <= hi1_q;
    end
  end

  // Stage 3: month from March = (5d - 3) / 153
  assign mp_y    = 11'(dn2_q) * 11'd5 - 11'd3;
  assign mp_prod = 22'(mp_y) * 22'(ets2c_pkg::Recip153);

  always_ff @(posedge clk_i) begin
    if (ld_i[3]) begin
      wday3_q <= wday2_q;
      mp_y3_q <= mp_y;
      mp3_q   <= mp_prod[21:18];
      yoe3_q  <= yoe2_q;
      hi3_q   <= hi2_q;
    end
  end

  // Stage 4: month remainder, January-based month, year and leap flag
  assign mp_x153 = 11'(mp3_q) * 11'd153;
  assign d4_d    = 8'(mp_y3_q - mp_x153);
  assign carry   = mp3_q >= 4'd10;
  assign month_d = carry ? (mp3_q - 4'd10) : (mp3_q + 4'd2);
  assign yoc     = yoe3_q + 7'(carry);
  // Year is 100 * century + yoc with century 19 or 20; yoc may reach 100
  assign yrs_d   = (hi3_q ? 8'd100 : 8'd0) + 8'(yoc);

  always_comb begin
    if (yoc == 7'd0) begin
      leap_d = hi3_q;         // century year 2000 is leap, 1900 is not
    end else if (yoc == 7'd100) begin
      leap_d = !hi3_q;        // rolled into 2000 from the 1900s era
    end else begin
      leap_d = (yoc[1:0] == 2'b00);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[4]) begin
      wday4_q  <= wday3_q;
      d4_4_q   <= d4_d;
      month4_q <= month_d;
      yrs4_q   <= yrs_d;
      leap4_q  <= leap_d;
    end
  end

  // Stage 5: day of month = (r + 5) / 5, then day of year
  assign d5_x     = d4_4_q + 8'd5;
  assign dom_prod = 16'(d5_x) * 16'(ets2c_pkg::Recip5);
  assign dom_d    = dom_prod[14:10];
  assign yday_d   = 9'(dom_d) - 9'd1 + ets2c_pkg::month_start(month4_q)
                  + 9'(leap4_q && (month4_q > 4'd1));

  always_ff @(posedge clk_i) begin
    if (ld_i[5]) begin
      date5_q <= '{weekday:          wday4_q,
                   years_since_1900: yrs4_q,
                   month:            month4_q,
                   day_of_month:     dom_d,
                   day_of_year:      yday_d};
    end
  end

  assign date_o = date5_q;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the epoch-to-calendar pipeline. A scoreboard
// predicts every calendar result from the transfers it sees on the input and
// matches the results in order. The offset register is stepped through its
// extremes. Random timestamps cluster around midnights, month starts, leap
// days and the ends of the 32-bit range, and both channels idle at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int     OffsetW    = ets2c_pkg::OffsetW;
  localparam int     EpochW     = ets2c_pkg::EpochW;
  localparam longint EpochMax   = longint'(32'sh7FFF_FFFF);
  localparam longint EpochMin   = longint'(32'sh8000_0000);
  localparam int     StallLimit = 2000;
  localparam int     DrainWait  = 12;
  localparam int     RandPerZone = 200;
  localparam int     CalmItems  = 40;
  localparam int     SecsPerDay = 86400;
  localparam int     MonthFirstDay [12] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  typedef struct packed {
    ets2c_pkg::tod_t  tod;
    ets2c_pkg::date_t date;
  } calendar_t;

  // Predict calendar results and match them against the pipeline output
  class calendar_scoreboard;
    longint      zone_offset;
    calendar_t   pending_q[$];
    int unsigned fail_count;

    function new();
      zone_offset = 0;
      fail_count  = 0;
    endfunction

    function void set_offset(logic signed [OffsetW-1:0] value);
      zone_offset = longint'(value);
    endfunction

    function calendar_t to_calendar(logic signed [EpochW-1:0] epoch);
      longint    t, days, sod, j, c, y, d, m, yday;
      calendar_t r;
      t    = longint'(epoch) + zone_offset;
      days = t / SecsPerDay;
      sod  = t % SecsPerDay;
      // floor toward minus infinity for times before the epoch
      if (sod < 0) begin
        sod  += SecsPerDay;
        days -= 1;
      end
      j = days + 719469;
      r.tod.second  = 6'(sod % 60);
      r.tod.minute  = 6'((sod / 60) % 60);
      r.tod.hour    = 5'(sod / 3600);
      r.date.weekday = 3'((j + 2) % 7);
      // era, year of era, then March-based month and day
      c = (4 * j - 1) / 146097;
      j = 4 * j - 1 - 146097 * c;
      d = j / 4;
      j = (4 * d + 3) / 1461;
      d = 4 * d + 3 - 1461 * j;
      d = (d + 4) / 4;
      m = (5 * d - 3) / 153;
      d = 5 * d - 3 - 153 * m;
      d = (d + 5) / 5;
      y = 100 * c + j;
      if (m < 10) begin
        m += 2;
      end else begin
        m -= 10;
        y += 1;
      end
      yday = d - 1 + MonthFirstDay[m];
      if (m > 1 && (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) begin
        yday += 1;
      end
      r.date.years_since_1900 = 8'(y - 1900);
      r.date.month            = 4'(m);
      r.date.day_of_month     = 5'(d);
      r.date.day_of_year      = 9'(yday);
      return r;
    endfunction

    function void note_time(logic signed [EpochW-1:0] epoch);
      pending_q.push_back(to_calendar(epoch));
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(calendar_t got);
      calendar_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        fail_count++;
        return;
      end
      want = pending_q.pop_front();
      compare_field("second", want.tod.second, got.tod.second);
      compare_field("minute", want.tod.minute, got.tod.minute);
      compare_field("hour", want.tod.hour, got.tod.hour);
      compare_field("weekday", want.date.weekday, got.date.weekday);
      compare_field("years_since_1900", want.date.years_since_1900,
                    got.date.years_since_1900);
      compare_field("month", want.date.month, got.date.month);
      compare_field("day_of_month", want.date.day_of_month, got.date.day_of_month);
      compare_field("day_of_year", want.date.day_of_year, got.date.day_of_year);
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic signed [OffsetW-1:0] cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic signed [EpochW-1:0]  epoch_seconds_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [5:0]                second_o;
  logic [5:0]                minute_o;
  logic [4:0]                hour_o;
  logic [2:0]                weekday_o;
  logic [7:0]                years_since_1900_o;
  logic [3:0]                month_o;
  logic [4:0]                day_of_month_o;
  logic [8:0]                day_of_year_o;

  logic                calm = 1'b0;
  int                  idle_cycles = 0;
  calendar_scoreboard  sb = new();

  epoch_seconds_to_calendar dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .epoch_seconds_i    (epoch_seconds_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .second_o           (second_o),
    .minute_o           (minute_o),
    .hour_o             (hour_o),
    .weekday_o          (weekday_o),
    .years_since_1900_o (years_since_1900_o),
    .month_o            (month_o),
    .day_of_month_o     (day_of_month_o),
    .day_of_year_o      (day_of_year_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Day number of a Gregorian date, 1970-01-01 is day 0
  function automatic longint civil_days(int y, int m, int d);
    int yy, era, yoe, doy, doe;
    yy  = (m <= 2) ? y - 1 : y;
    era = yy / 400;
    yoe = yy - era * 400;
    doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return longint'(era) * 146097 + doe - 719468;
  endfunction

  // Random timestamp, weighted toward local-time edges of the calendar
  function automatic longint pick_epoch();
    int     sel, jitter, yr, mo;
    longint t;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      t = longint'($signed($urandom));
    end else if (sel < 50) begin
      jitter = $urandom_range(0, 49710);
      t = longint'(jitter - 24855) * SecsPerDay - sb.zone_offset;
      jitter = $urandom_range(0, 6);
      t += jitter - 3;
    end else if (sel < 70) begin
      yr = $urandom_range(1902, 2037);
      mo = $urandom_range(1, 12);
      jitter = $urandom_range(0, 2 * SecsPerDay);
      t = civil_days(yr, mo, 1) * SecsPerDay - sb.zone_offset + jitter - SecsPerDay;
    end else if (sel < 85) begin
      yr = 4 * $urandom_range(476, 509);
      jitter = $urandom_range(0, 3 * SecsPerDay - 1);
      t = civil_days(yr, 2, 28) * SecsPerDay - sb.zone_offset + jitter;
    end else begin
      jitter = $urandom_range(0, 300000);
      t = $urandom_range(0, 1) ? EpochMax - jitter : EpochMin + jitter;
    end
    if (t > EpochMax) t = EpochMax;
    if (t < EpochMin) t = EpochMin;
    return t;
  endfunction

  // Present one timestamp and hold it until the transfer
  task automatic send_time(input longint t, input bit quiet);
    int gap;
    gap = quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    epoch_seconds_i <= EpochW'(t);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Write the zone offset once the pipeline has drained
  task automatic write_offset(input logic signed [OffsetW-1:0] value);
    // let the monitor note a transfer made at the current edge first
    @(negedge clk_i);
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_offset(value);
  endtask

  // Stall the output at random, never while calm
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      if (!calm) begin
        out_stall_i <= 1'b1;
        repeat (1 + gap_len()) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Check results first, then note new input transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result({second_o, minute_o, hour_o, weekday_o, years_since_1900_o,
                         month_o, day_of_month_o, day_of_year_o});
      end
      if (in_valid_i && !in_stall_o) begin
        sb.note_time(epoch_seconds_i);
      end
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Abort when nothing moves for too long
  initial begin
    while (idle_cycles < StallLimit) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  initial begin
    longint                    directed_q[$];
    logic signed [OffsetW-1:0] zone_plan[8];
    int                        p, k;

    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    in_valid_i      <= 1'b0;
    epoch_seconds_i <= '0;

    directed_q = '{0, -1, EpochMax, EpochMin, 86399, 86400, -86400, -86401,
                   civil_days(2000, 2, 29) * SecsPerDay + 86399,
                   civil_days(2000, 12, 31) * SecsPerDay + 86399,
                   civil_days(2001, 1, 1) * SecsPerDay,
                   civil_days(1904, 2, 29) * SecsPerDay,
                   civil_days(1904, 12, 31) * SecsPerDay + 43200,
                   civil_days(1969, 3, 1) * SecsPerDay - 1,
                   civil_days(2037, 12, 31) * SecsPerDay + 86399,
                   civil_days(1902, 1, 1) * SecsPerDay,
                   civil_days(2024, 3, 1) * SecsPerDay - 1,
                   civil_days(1970, 1, 4) * SecsPerDay};

    // Zone offsets: reset value, stated limits, full 17-bit extremes, random
    zone_plan[0] = '0;
    zone_plan[1] = 17'sd50400;
    zone_plan[2] = -17'sd50400;
    zone_plan[3] = 17'sh0FFFF;
    zone_plan[4] = 17'sh10000;
    zone_plan[5] = OffsetW'($urandom_range(0, 100800) - 50400);
    zone_plan[6] = OffsetW'($urandom);
    zone_plan[7] = -17'sd1;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (p = 0; p < 8; p++) begin
      write_offset(zone_plan[p]);
      if (p == 0) begin
        foreach (directed_q[i]) send_time(directed_q[i], 1'b0);
      end else begin
        for (k = 0; k < 4; k++) send_time(directed_q[k], 1'b0);
      end
      // run a calm stretch, then random idling on both sides
      calm <= 1'b1;
      for (k = 0; k < RandPerZone; k++) begin
        if (k == CalmItems) calm <= 1'b0;
        send_time(pick_epoch(), k < CalmItems);
      end
      in_valid_i <= 1'b0;
    end

    // let the monitor note the last transfer before draining
    @(negedge clk_i);
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/ets2c_pkg.sv
design/ets2c_pipe_ctrl.sv
design/ets2c_day_split.sv
design/ets2c_time_of_day.sv
design/ets2c_civil_date.sv
design/epoch_seconds_to_calendar.sv
tb/sv/tb.sv
